### sv/tuv_pkg.sv
// ----------------------------------------------------------------------------
// tuv_pkg
// Shared types and constants of the triangle UV interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tuv_pkg;

    localparam logic [1:0] FUNC_LOAD_UV  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_POS = 2'd1;
    localparam logic [1:0] FUNC_QUERY    = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    localparam logic REG_VERTEX_COUNT  = 1'b0;
    localparam logic REG_DET_THRESHOLD = 1'b1;

    localparam logic [31:0] DET_THRESHOLD_RESET = 32'd429;

    // divider: 31 integer + 16 fraction + 1 rounding quotient bits
    localparam int DIV_STEPS = 48;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    localparam int NUM_W     = 59;
    localparam int DEN_W     = 51;

    typedef struct packed {
        logic [1:0]         func;
        logic [9:0]         index_a;
        logic [9:0]         index_b;
        logic [9:0]         index_c;
        logic [16:0]        weight_a;
        logic [16:0]        weight_b;
        logic [16:0]        weight_c;
        logic               want_derivatives;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } t_in;

    typedef struct packed {
        logic               status;
        logic signed [23:0] coord_u;
        logic signed [23:0] coord_v;
        logic               has_derivs;
        logic signed [31:0] dpdu_x;
        logic signed [31:0] dpdu_y;
        logic signed [31:0] dpdu_z;
        logic signed [31:0] dpdv_x;
        logic signed [31:0] dpdv_y;
        logic signed [31:0] dpdv_z;
    } t_out;

    // control that rides along the divider
    typedef struct packed {
        logic               valid;
        logic               status;
        logic               has;
        logic signed [23:0] coord_u;
        logic signed [23:0] coord_v;
    } t_side;

    function automatic logic signed [23:0] sat24(input logic signed [31:0] x);
        logic signed [23:0] r;
        if (x > 32'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (x < -32'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = x[23:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/tuv_ram.sv
// ----------------------------------------------------------------------------
// tuv_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tuv_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/tuv_div.sv
// ----------------------------------------------------------------------------
// tuv_div
// Pipelined restoring divider, one quotient bit per stage. Returns
// num/den in Q16.16, rounded half away from zero, signed, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module tuv_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [tuv_pkg::NUM_W-1:0]     i_num,
    input  wire logic [tuv_pkg::DEN_W-1:0]     i_den,
    input  wire logic                          i_neg,
    output logic signed [31:0]                 o_res
);

    localparam int STEPS = tuv_pkg::DIV_STEPS;
    localparam int RW    = tuv_pkg::DEN_W + 1;

    logic [RW-1:0]               c_rem  [STEPS+1];
    logic [STEPS-1:0]            c_strm [STEPS+1];
    logic [STEPS-1:0]            c_q    [STEPS+1];
    logic [tuv_pkg::DEN_W-1:0]   c_den  [STEPS+1];
    logic                        c_neg  [STEPS+1];
    logic                        c_sat  [STEPS+1];

    logic [RW-1:0]               r_rem  [STEPS];
    logic [STEPS-1:0]            r_strm [STEPS];
    logic [STEPS-1:0]            r_q    [STEPS];
    logic [tuv_pkg::DEN_W-1:0]   r_den  [STEPS];
    logic                        r_neg  [STEPS];
    logic                        r_sat  [STEPS];

    // quotient >= 2^31 exactly when num / 2^31 >= den
    assign c_rem[0]  = RW'(i_num[58:31]);
    assign c_strm[0] = {i_num[30:0], 17'd0};
    assign c_q[0]    = '0;
    assign c_den[0]  = i_den;
    assign c_neg[0]  = i_neg;
    assign c_sat[0]  = tuv_pkg::DEN_W'(i_num[58:31]) >= i_den;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [RW-1:0] t;
        logic          ge;

        assign t  = {c_rem[g][RW-2:0], c_strm[g][STEPS-1]};
        assign ge = t >= {1'b0, c_den[g]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? t - {1'b0, c_den[g]} : t;
                r_strm[g] <= {c_strm[g][STEPS-2:0], 1'b0};
                r_q[g]    <= {c_q[g][STEPS-2:0], ge};
                r_den[g]  <= c_den[g];
                r_neg[g]  <= c_neg[g];
                r_sat[g]  <= c_sat[g];
            end
        end

        assign c_rem[g+1]  = r_rem[g];
        assign c_strm[g+1] = r_strm[g];
        assign c_q[g+1]    = r_q[g];
        assign c_den[g+1]  = r_den[g];
        assign c_neg[g+1]  = r_neg[g];
        assign c_sat[g+1]  = r_sat[g];
    end

    logic [STEPS:0]      sum;
    logic [STEPS-1:0]    rnd;
    logic signed [31:0]  n_res;
    logic signed [31:0]  r_res;

    always_comb begin
        sum = {1'b0, c_q[STEPS]} + (STEPS+1)'(1);
        rnd = sum[STEPS:1];
        if (c_neg[STEPS]) begin
            if (c_sat[STEPS] || rnd > STEPS'(32'h8000_0000)) begin
                n_res = 32'sh8000_0000;
            end else begin
                n_res = -$signed(rnd[31:0]);
            end
        end else begin
            if (c_sat[STEPS] || rnd > STEPS'(32'h7FFF_FFFF)) begin
                n_res = 32'sh7FFF_FFFF;
            end else begin
                n_res = $signed(rnd[31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

### sv/triangle_uv_interpolator.sv
// ----------------------------------------------------------------------------
// triangle_uv_interpolator
// Vertex UV / position tables with barycentric UV lookup and dP/du, dP/dv.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in  (tuv_pkg::t_in)
// out       output     o_out_valid / i_out_stall  o_out (tuv_pkg::t_out)
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled. Each item passes the
// table read, multiply and rounding stages and the 48-stage divider, one
// quotient bit per stage. The whole pipeline advances
// together and holds while the output register is full and stalled.
// Reset (synchronous) clears valid bits, presets config; tables not cleared.
// Each table is kept in three copies so that three vertices read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_uv_interpolator #(
    parameter int VERTICES = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire tuv_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output tuv_pkg::t_out      o_out,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);

    localparam int AW = $clog2(VERTICES);
    localparam int XW = AW + 10;

    logic [10:0] r_vertex_count;
    logic [31:0] r_det_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count  <= '0;
            r_det_threshold <= tuv_pkg::DET_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tuv_pkg::REG_VERTEX_COUNT:  r_vertex_count  <= i_cfg_data[10:0];
                tuv_pkg::REG_DET_THRESHOLD: r_det_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the output holds a stalled result
    logic en;
    logic accept;
    logic r_out_valid;

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;
    assign accept     = i_in_valid && en;

    // ---------------- stage 0: index checks, table access ----------------
    logic [9:0]    idx [3];
    logic [AW-1:0] raddr [3];
    logic          in_tab [3];
    logic          in_cnt [3];
    logic [XW-1:0] xaddr [3];

    assign idx[0] = i_in.index_a;
    assign idx[1] = i_in.index_b;
    assign idx[2] = i_in.index_c;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            xaddr[k]  = XW'(idx[k]);
            raddr[k]  = xaddr[k][AW-1:0];
            in_tab[k] = 32'(idx[k]) < 32'(VERTICES);
            in_cnt[k] = in_tab[k] && (11'(idx[k]) < r_vertex_count);
        end
    end

    logic is_load;
    logic is_query;
    logic n1_status;
    logic n1_q_ok;
    logic we_uv;
    logic we_pos;

    always_comb begin
        is_load   = (i_in.func == tuv_pkg::FUNC_LOAD_UV) ||
                    (i_in.func == tuv_pkg::FUNC_LOAD_POS);
        is_query  = i_in.func == tuv_pkg::FUNC_QUERY;
        n1_q_ok   = is_query && in_cnt[0] && in_cnt[1] && in_cnt[2];
        n1_status = (is_load && !in_tab[0]) || (is_query && !n1_q_ok);
        we_uv     = accept && in_tab[0] && (i_in.func == tuv_pkg::FUNC_LOAD_UV);
        we_pos    = accept && in_tab[0] && (i_in.func == tuv_pkg::FUNC_LOAD_POS);
    end

    logic [47:0] uv_wdata;
    logic [95:0] pos_wdata;
    logic [47:0] uv_rd  [3];
    logic [95:0] pos_rd [3];

    assign uv_wdata  = {tuv_pkg::sat24(i_in.value_x), tuv_pkg::sat24(i_in.value_y)};
    assign pos_wdata = {i_in.value_x, i_in.value_y, i_in.value_z};

    for (genvar g = 0; g < 3; g++) begin : g_tab
        tuv_ram #(.WIDTH(48), .DEPTH(VERTICES)) u_uv_ram (
            .i_clk   (i_clk),
            .i_we    (we_uv),
            .i_waddr (raddr[0]),
            .i_wdata (uv_wdata),
            .i_re    (en),
            .i_raddr (raddr[g]),
            .o_rdata (uv_rd[g])
        );
        tuv_ram #(.WIDTH(96), .DEPTH(VERTICES)) u_pos_ram (
            .i_clk   (i_clk),
            .i_we    (we_pos),
            .i_waddr (raddr[0]),
            .i_wdata (pos_wdata),
            .i_re    (en),
            .i_raddr (raddr[g]),
            .o_rdata (pos_rd[g])
        );
    end

    logic        r1_valid;
    logic        r1_status;
    logic        r1_q_ok;
    logic        r1_want;
    logic [16:0] r1_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_status <= n1_status;
            r1_q_ok   <= n1_q_ok;
            r1_want   <= i_in.want_derivatives;
            r1_w[0]   <= i_in.weight_a;
            r1_w[1]   <= i_in.weight_b;
            r1_w[2]   <= i_in.weight_c;
        end
    end

    // ---------------- stage 1: weight products, differences ----------------
    logic signed [23:0] u1 [3];
    logic signed [23:0] v1 [3];
    logic signed [31:0] p1 [3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u1[k]    = $signed(uv_rd[k][47:24]);
            v1[k]    = $signed(uv_rd[k][23:0]);
            p1[k][0] = $signed(pos_rd[k][95:64]);
            p1[k][1] = $signed(pos_rd[k][63:32]);
            p1[k][2] = $signed(pos_rd[k][31:0]);
        end
    end

    logic               r2_valid;
    logic               r2_status;
    logic               r2_q_ok;
    logic               r2_want;
    logic signed [41:0] r2_pu [3];
    logic signed [41:0] r2_pv [3];
    logic signed [24:0] r2_du02;
    logic signed [24:0] r2_dv02;
    logic signed [24:0] r2_du12;
    logic signed [24:0] r2_dv12;
    logic signed [32:0] r2_dp02 [3];
    logic signed [32:0] r2_dp12 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_status <= r1_status;
            r2_q_ok   <= r1_q_ok;
            r2_want   <= r1_want;
            for (int k = 0; k < 3; k++) begin
                r2_pu[k]   <= u1[k] * $signed({1'b0, r1_w[k]});
                r2_pv[k]   <= v1[k] * $signed({1'b0, r1_w[k]});
                r2_dp02[k] <= 33'(p1[0][k]) - 33'(p1[2][k]);
                r2_dp12[k] <= 33'(p1[1][k]) - 33'(p1[2][k]);
            end
            r2_du02 <= 25'(u1[0]) - 25'(u1[2]);
            r2_dv02 <= 25'(v1[0]) - 25'(v1[2]);
            r2_du12 <= 25'(u1[1]) - 25'(u1[2]);
            r2_dv12 <= 25'(v1[1]) - 25'(v1[2]);
        end
    end

    // ---------------- stage 2: UV sum, cross products ----------------
    logic signed [43:0] su;
    logic signed [43:0] sv;
    logic signed [23:0] n3_cu;
    logic signed [23:0] n3_cv;

    always_comb begin
        // round half up to Q8.16
        su    = 44'(r2_pu[0]) + 44'(r2_pu[1]) + 44'(r2_pu[2]) + 44'sd32768;
        sv    = 44'(r2_pv[0]) + 44'(r2_pv[1]) + 44'(r2_pv[2]) + 44'sd32768;
        n3_cu = r2_q_ok ? tuv_pkg::sat24(32'($signed(su[43:16]))) : '0;
        n3_cv = r2_q_ok ? tuv_pkg::sat24(32'($signed(sv[43:16]))) : '0;
    end

    logic               r3_valid;
    logic               r3_status;
    logic               r3_q_ok;
    logic               r3_want;
    logic signed [23:0] r3_cu;
    logic signed [23:0] r3_cv;
    logic signed [49:0] r3_det0;
    logic signed [49:0] r3_det1;
    logic signed [57:0] r3_nu0 [3];
    logic signed [57:0] r3_nu1 [3];
    logic signed [57:0] r3_nv0 [3];
    logic signed [57:0] r3_nv1 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_status <= r2_status;
            r3_q_ok   <= r2_q_ok;
            r3_want   <= r2_want;
            r3_cu     <= n3_cu;
            r3_cv     <= n3_cv;
            r3_det0   <= r2_du02 * r2_dv12;
            r3_det1   <= r2_dv02 * r2_du12;
            for (int k = 0; k < 3; k++) begin
                r3_nu0[k] <= r2_dp02[k] * r2_dv12;
                r3_nu1[k] <= r2_dp12[k] * r2_dv02;
                r3_nv0[k] <= r2_dp12[k] * r2_du02;
                r3_nv1[k] <= r2_dp02[k] * r2_du12;
            end
        end
    end

    // ---------------- stage 3: determinant, numerators ----------------
    logic               r4_valid;
    logic               r4_status;
    logic               r4_q_ok;
    logic               r4_want;
    logic signed [23:0] r4_cu;
    logic signed [23:0] r4_cv;
    logic signed [50:0] r4_det;
    logic signed [58:0] r4_nu [3];
    logic signed [58:0] r4_nv [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_status <= r3_status;
            r4_q_ok   <= r3_q_ok;
            r4_want   <= r3_want;
            r4_cu     <= r3_cu;
            r4_cv     <= r3_cv;
            r4_det    <= 51'(r3_det0) - 51'(r3_det1);
            for (int k = 0; k < 3; k++) begin
                r4_nu[k] <= 59'(r3_nu0[k]) - 59'(r3_nu1[k]);
                r4_nv[k] <= 59'(r3_nv0[k]) - 59'(r3_nv1[k]);
            end
        end
    end

    // ---------------- stage 4: magnitudes, threshold ----------------
    logic [50:0] dmag;

    assign dmag = r4_det[50] ? 51'(-r4_det) : 51'(r4_det);

    tuv_pkg::t_side            r5_side;
    logic [50:0]               r5_dmag;
    logic [58:0]               r5_num [6];
    logic                      r5_neg [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_side.valid <= 1'b0;
        end else if (en) begin
            r5_side.valid   <= r4_valid;
            r5_side.status  <= r4_status;
            r5_side.coord_u <= r4_cu;
            r5_side.coord_v <= r4_cv;
            r5_side.has     <= r4_q_ok && r4_want && (r4_det != '0) &&
                               (dmag >= 51'(r_det_threshold));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_dmag         <= dmag;
            for (int k = 0; k < 3; k++) begin
                r5_num[k]   <= r4_nu[k][58] ? 59'(-r4_nu[k]) : 59'(r4_nu[k]);
                r5_neg[k]   <= r4_nu[k][58] ^ r4_det[50];
                r5_num[k+3] <= r4_nv[k][58] ? 59'(-r4_nv[k]) : 59'(r4_nv[k]);
                r5_neg[k+3] <= r4_nv[k][58] ^ r4_det[50];
            end
        end
    end

    // ---------------- divider lanes and control delay line ----------------
    logic signed [31:0] quo [6];

    for (genvar g = 0; g < 6; g++) begin : g_div
        tuv_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r5_num[g]),
            .i_den (r5_dmag),
            .i_neg (r5_neg[g]),
            .o_res (quo[g])
        );
    end

    tuv_pkg::t_side r_side [tuv_pkg::DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < tuv_pkg::DIV_LAT; s++) begin
                r_side[s] <= '0;
            end
        end else if (en) begin
            r_side[0] <= r5_side;
            for (int s = 1; s < tuv_pkg::DIV_LAT; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // ---------------- output register ----------------
    tuv_pkg::t_side last;
    tuv_pkg::t_out  n_out;
    tuv_pkg::t_out  r_out;

    assign last = r_side[tuv_pkg::DIV_LAT-1];

    always_comb begin
        n_out.status     = last.status;
        n_out.coord_u    = last.coord_u;
        n_out.coord_v    = last.coord_v;
        n_out.has_derivs = last.has;
        n_out.dpdu_x     = last.has ? quo[0] : '0;
        n_out.dpdu_y     = last.has ? quo[1] : '0;
        n_out.dpdu_z     = last.has ? quo[2] : '0;
        n_out.dpdv_x     = last.has ? quo[3] : '0;
        n_out.dpdv_y     = last.has ? quo[4] : '0;
        n_out.dpdv_z     = last.has ? quo[5] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### tb/sv/triangle_uv_interpolator_tb.sv
// ----------------------------------------------------------------------------
// triangle_uv_interpolator_tb
// Self-checking bench: loads vertex tables, runs directed and random queries
// under several register settings with random gaps and output stalls, and
// compares every result with a cycle-free predictor of the interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_uv_interpolator_tb;

    localparam int NVERT   = 1024;
    localparam int WDOG    = 3000;
    localparam int SQUEEZE = 400;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    tuv_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_stall;
    tuv_pkg::t_out o_out;
    logic          i_cfg_we;
    logic          i_cfg_index;
    logic [31:0]   i_cfg_data;

    triangle_uv_interpolator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    int          tex_u [NVERT];
    int          tex_v [NVERT];
    int          pos   [NVERT][3];
    bit          has_uv [NVERT];
    bit          has_pos[NVERT];
    int          ready_verts[$];
    logic [10:0] num_verts;
    logic [31:0] min_det;

    tuv_pkg::t_out awaited[$];
    int            errors;
    int            idle_cycles;
    bit            steady;
    bit            squeeze_req;

    typedef struct {
        bit            is_cfg;
        logic          cfg_idx;
        logic [31:0]   cfg_data;
        tuv_pkg::t_in  item;
        bit            fixed;
        tuv_pkg::t_out res;
    } t_row;

    t_row script[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp(longint x, int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    // quotient scaled by 2^16, round half away from zero, saturate to 32 bits
    function automatic longint div_q16(longint num, longint den);
        bit                neg;
        longint unsigned   n;
        longint unsigned   d;
        longint unsigned   q;
        longint unsigned   rm;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        rm = n % d;
        if (q >= 64'h8000_0000) begin
            q = 64'd1 << 48;
        end else begin
            for (int i = 0; i < 16; i++) begin
                rm = rm << 1;
                q = q << 1;
                if (rm >= d) begin
                    rm = rm - d;
                    q = q | 1;
                end
            end
            rm = rm << 1;
            if (rm >= d) q++;
        end
        return clamp(neg ? -longint'(q) : longint'(q), 32);
    endfunction

    function automatic tuv_pkg::t_out predict_result(tuv_pkg::t_in x);
        tuv_pkg::t_out r;
        int     a, b, c;
        longint lim, su, sv, t, du02, dv02, du12, dv12, det, d02, d12;
        longint dpu[3];
        longint dpv[3];
        r = '0;
        a = x.index_a;
        b = x.index_b;
        c = x.index_c;
        case (x.func)
            tuv_pkg::FUNC_LOAD_UV: begin
                tex_u[a] = clamp(longint'(x.value_x), 24);
                tex_v[a] = clamp(longint'(x.value_y), 24);
                has_uv[a] = 1'b1;
                if (has_pos[a] && !(a inside {ready_verts})) ready_verts.push_back(a);
            end
            tuv_pkg::FUNC_LOAD_POS: begin
                pos[a][0] = x.value_x;
                pos[a][1] = x.value_y;
                pos[a][2] = x.value_z;
                has_pos[a] = 1'b1;
                if (has_uv[a] && !(a inside {ready_verts})) ready_verts.push_back(a);
            end
            tuv_pkg::FUNC_QUERY: begin
                lim = (num_verts < NVERT) ? num_verts : NVERT;
                if (a >= lim || b >= lim || c >= lim) begin
                    r.status = 1'b1;
                    return r;
                end
                su = longint'(tex_u[a]) * longint'(x.weight_a)
                   + longint'(tex_u[b]) * longint'(x.weight_b)
                   + longint'(tex_u[c]) * longint'(x.weight_c);
                sv = longint'(tex_v[a]) * longint'(x.weight_a)
                   + longint'(tex_v[b]) * longint'(x.weight_b)
                   + longint'(tex_v[c]) * longint'(x.weight_c);
                t = clamp((su + 32768) >>> 16, 24);
                r.coord_u = t;
                t = clamp((sv + 32768) >>> 16, 24);
                r.coord_v = t;
                if (!x.want_derivatives) return r;
                du02 = longint'(tex_u[a]) - tex_u[c];
                dv02 = longint'(tex_v[a]) - tex_v[c];
                du12 = longint'(tex_u[b]) - tex_u[c];
                dv12 = longint'(tex_v[b]) - tex_v[c];
                det = du02 * dv12 - dv02 * du12;
                if (det == 0) return r;
                if (((det < 0) ? -det : det) < longint'(min_det)) return r;
                r.has_derivs = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    d02 = longint'(pos[a][k]) - pos[c][k];
                    d12 = longint'(pos[b][k]) - pos[c][k];
                    dpu[k] = div_q16(d02 * dv12 - d12 * dv02, det);
                    dpv[k] = div_q16(d12 * du02 - d02 * du12, det);
                end
                r.dpdu_x = dpu[0];
                r.dpdu_y = dpu[1];
                r.dpdu_z = dpu[2];
                r.dpdv_x = dpv[0];
                r.dpdv_y = dpv[1];
                r.dpdv_z = dpv[2];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_row load_row(logic [1:0] f, int idx, int x, int y, int z);
        t_row r;
        r = '{default: '0};
        r.item.func = f;
        r.item.index_a = idx;
        r.item.value_x = x;
        r.item.value_y = y;
        r.item.value_z = z;
        r.fixed = 1'b1;
        return r;
    endfunction

    function automatic t_row query_row(int a, int b, int c, int wa, int wb, int wc,
                                       bit want, bit bad_index);
        t_row r;
        r = '{default: '0};
        r.item.func = tuv_pkg::FUNC_QUERY;
        r.item.index_a = a;
        r.item.index_b = b;
        r.item.index_c = c;
        r.item.weight_a = wa;
        r.item.weight_b = wb;
        r.item.weight_c = wc;
        r.item.want_derivatives = want;
        r.fixed = bad_index;
        r.res.status = bad_index;
        return r;
    endfunction

    function automatic t_row cfg_row(logic idx, logic [31:0] d);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_data = d;
        return r;
    endfunction

    task automatic send_item(tuv_pkg::t_in x, bit fixed, tuv_pkg::t_out res);
        int            gap;
        tuv_pkg::t_out p;
        gap = steady ? 0 : $urandom_range(0, 17);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in = x;
        do @(posedge i_clk); while (o_in_stall);
        p = predict_result(x);
        awaited.push_back(fixed ? res : p);
    endtask

    // drop valid before the next edge so the last item is not sent twice
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] d);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == tuv_pkg::REG_VERTEX_COUNT) num_verts = d[10:0];
        else min_det = d;
    endtask

    task automatic check_result(tuv_pkg::t_out got);
        tuv_pkg::t_out e;
        if (awaited.size() == 0) begin
            $error("unexpected result transfer %h", got);
            errors++;
            return;
        end
        e = awaited.pop_front();
        if (got.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, got.status); errors++;
        end
        if (got.coord_u !== e.coord_u) begin
            $error("coord_u exp %0d got %0d", e.coord_u, got.coord_u); errors++;
        end
        if (got.coord_v !== e.coord_v) begin
            $error("coord_v exp %0d got %0d", e.coord_v, got.coord_v); errors++;
        end
        if (got.has_derivs !== e.has_derivs) begin
            $error("has_derivs exp %0d got %0d", e.has_derivs, got.has_derivs); errors++;
        end
        if (got.dpdu_x !== e.dpdu_x) begin
            $error("dpdu_x exp %0d got %0d", e.dpdu_x, got.dpdu_x); errors++;
        end
        if (got.dpdu_y !== e.dpdu_y) begin
            $error("dpdu_y exp %0d got %0d", e.dpdu_y, got.dpdu_y); errors++;
        end
        if (got.dpdu_z !== e.dpdu_z) begin
            $error("dpdu_z exp %0d got %0d", e.dpdu_z, got.dpdu_z); errors++;
        end
        if (got.dpdv_x !== e.dpdv_x) begin
            $error("dpdv_x exp %0d got %0d", e.dpdv_x, got.dpdv_x); errors++;
        end
        if (got.dpdv_y !== e.dpdv_y) begin
            $error("dpdv_y exp %0d got %0d", e.dpdv_y, got.dpdv_y); errors++;
        end
        if (got.dpdv_z !== e.dpdv_z) begin
            $error("dpdv_z exp %0d got %0d", e.dpdv_z, got.dpdv_z); errors++;
        end
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endfunction

    function automatic int rand_weight();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65536;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // a vertex that is loaded and in range; raw random indices now and then
    function automatic int pick_vertex(int lim);
        int v;
        if ($urandom_range(0, 9) == 0) begin
            v = $urandom_range(0, NVERT - 1);
            if (v >= lim || (has_uv[v] && has_pos[v])) return v;
        end
        do v = ready_verts[$urandom_range(0, ready_verts.size() - 1)]; while (v >= lim);
        return v;
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin
        int hold;
        i_out_stall = 1'b0;
        hold = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                hold--;
            end else begin
                i_out_stall = 1'b0;
            end
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                check_result(o_out);
                if (squeeze_req) begin
                    hold = SQUEEZE;
                    squeeze_req = 1'b0;
                end else begin
                    hold = steady ? 0 : $urandom_range(0, 17);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG) begin
                $display("[triangle_uv_interpolator] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int            lim, a, b, c, f;
        logic [31:0]   vc_set [6] = '{1024, 2047, 600, 3, 1024, 300};
        logic [31:0]   th_set [6] = '{429, 0, 1000, 32'hFFFF_FFFF, 1, 32'h8000};
        tuv_pkg::t_in  x;
        tuv_pkg::t_out none;

        errors = 0;
        steady = 1'b0;
        squeeze_req = 1'b0;
        num_verts = '0;
        min_det = tuv_pkg::DET_THRESHOLD_RESET;
        none = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = tuv_pkg::REG_VERTEX_COUNT;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part; vertex count is zero out of reset
        script.push_back(load_row(tuv_pkg::FUNC_LOAD_UV, 0, 32'h007F_FFFF, 32'hFF80_0000, 0));
        script.push_back(load_row(tuv_pkg::FUNC_LOAD_UV, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        script.push_back(load_row(tuv_pkg::FUNC_LOAD_UV, 2, 32'h0001_0000, 0, 32'hFFFF_FFFF));
        script.push_back(load_row(tuv_pkg::FUNC_LOAD_UV, 1023, 0, 32'h0001_0000, 0));
        script.push_back(load_row(tuv_pkg::FUNC_LOAD_POS, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h0001_0000));
        script.push_back(load_row(tuv_pkg::FUNC_LOAD_POS, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        script.push_back(load_row(tuv_pkg::FUNC_LOAD_POS, 2, 0, 32'h0001_0000, 32'hFFFF_FFFF));
        script.push_back(load_row(tuv_pkg::FUNC_LOAD_POS, 1023, 32'h0003_0000, -65536,
                                  32'h7FFF_FFFF));
        script.push_back(load_row(tuv_pkg::FUNC_RESERVED, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF));
        script.push_back(query_row(0, 1, 2, 65536, 0, 0, 1, 1));
        script.push_back(cfg_row(tuv_pkg::REG_VERTEX_COUNT, 1024));
        script.push_back(query_row(0, 1, 2, 65536, 0, 0, 1, 0));
        script.push_back(query_row(0, 1, 1023, 65536, 65536, 65536, 1, 0));
        script.push_back(query_row(2, 1023, 0, 21845, 21845, 21846, 1, 0));
        script.push_back(query_row(0, 0, 1, 32768, 32768, 0, 1, 0));
        script.push_back(query_row(1023, 2, 1, 0, 0, 65536, 0, 0));
        script.push_back(cfg_row(tuv_pkg::REG_DET_THRESHOLD, 0));
        script.push_back(query_row(2, 2, 1023, 65536, 0, 0, 1, 0));
        script.push_back(query_row(0, 2, 1023, 1, 65535, 0, 1, 0));
        script.push_back(cfg_row(tuv_pkg::REG_DET_THRESHOLD, 32'hFFFF_FFFF));
        script.push_back(query_row(0, 2, 1023, 1, 65535, 0, 1, 0));
        script.push_back(cfg_row(tuv_pkg::REG_VERTEX_COUNT, 3));
        script.push_back(query_row(0, 1, 1023, 65536, 0, 0, 1, 1));
        script.push_back(query_row(3, 0, 1, 65536, 0, 0, 0, 1));
        script.push_back(cfg_row(tuv_pkg::REG_VERTEX_COUNT, 2047));
        script.push_back(query_row(1023, 1, 2, 65536, 65536, 0, 1, 0));

        foreach (script[i]) begin
            if (script[i].is_cfg)
                write_reg(script[i].cfg_idx, script[i].cfg_data);
            else
                send_item(script[i].item, script[i].fixed, script[i].res);
        end

        // random phases, one per register setting
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(tuv_pkg::REG_VERTEX_COUNT, vc_set[ph]);
            write_reg(tuv_pkg::REG_DET_THRESHOLD, th_set[ph]);
            lim = (vc_set[ph] < NVERT) ? vc_set[ph] : NVERT;
            steady = (ph == 4);
            if (ph == 2) squeeze_req = 1'b1;
            for (int n = 0; n < 12; n++) begin
                a = (n < 3) ? n : $urandom_range(0, NVERT - 1);
                for (int k = 0; k < 2; k++) begin
                    x = '0;
                    x.func = k ? tuv_pkg::FUNC_LOAD_POS : tuv_pkg::FUNC_LOAD_UV;
                    x.index_a = a;
                    x.index_b = $urandom;
                    x.index_c = $urandom;
                    x.weight_a = $urandom;
                    x.value_x = rand_coord();
                    x.value_y = rand_coord();
                    x.value_z = $urandom;
                    send_item(x, 1'b0, none);
                end
            end
            for (int n = 0; n < 70; n++) begin
                x = '0;
                f = $urandom_range(0, 19);
                x.weight_a = rand_weight();
                x.weight_b = rand_weight();
                x.weight_c = rand_weight();
                x.want_derivatives = ($urandom_range(0, 3) != 0);
                x.value_x = rand_coord();
                x.value_y = rand_coord();
                x.value_z = rand_coord();
                if (f < 14) begin
                    a = pick_vertex(lim);
                    b = pick_vertex(lim);
                    c = ($urandom_range(0, 9) == 0) ? a : pick_vertex(lim);
                    x.func = tuv_pkg::FUNC_QUERY;
                    x.index_a = a;
                    x.index_b = b;
                    x.index_c = c;
                end else begin
                    x.func = (f == 19) ? tuv_pkg::FUNC_RESERVED :
                             ((f < 17) ? tuv_pkg::FUNC_LOAD_UV : tuv_pkg::FUNC_LOAD_POS);
                    x.index_a = $urandom;
                    x.index_b = $urandom;
                    x.index_c = $urandom;
                end
                send_item(x, 1'b0, none);
            end
        end

        drain();
        repeat (80) @(posedge i_clk);
        if (errors == 0)
            $display("[triangle_uv_interpolator] OK");
        else
            $display("[triangle_uv_interpolator] ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/tuv_pkg.sv
sv/tuv_ram.sv
sv/tuv_div.sv
sv/triangle_uv_interpolator.sv
tb/sv/triangle_uv_interpolator_tb.sv
